[hdl/helt_pkg.sv]
// ----------------------------------------------------------------------------
// helt_pkg
// Shared types and constants of the escalation level tracker: register
// indexes, register reset values, score scaling and stream field layout.
// ----------------------------------------------------------------------------
`default_nettype none

package helt_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_LEVEL_LIMIT    = 3'd0;
    localparam logic [2:0] REG_WAVE_UP        = 3'd1;
    localparam logic [2:0] REG_WAVE_DOWN      = 3'd2;
    localparam logic [2:0] REG_TAINT_UP       = 3'd3;
    localparam logic [2:0] REG_TAINT_DOWN     = 3'd4;
    localparam logic [2:0] REG_HOLD_RELOAD    = 3'd5;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 17;
    localparam int LIMIT_W     = 4;
    localparam int THR_W       = 17;
    localparam int HOLD_W      = 8;
    localparam int SCORE_W     = 18;

    // register reset values
    localparam logic [LIMIT_W-1:0] LIMIT_RST      = 4'd3;
    localparam logic [THR_W-1:0]   WAVE_UP_RST    = 17'd40632;
    localparam logic [THR_W-1:0]   WAVE_DOWN_RST  = 17'd18350;
    localparam logic [THR_W-1:0]   TAINT_UP_RST   = 17'd38012;
    localparam logic [THR_W-1:0]   TAINT_DOWN_RST = 17'd15729;
    localparam logic [HOLD_W-1:0]  HOLD_RST       = 8'd2;

    // 1.0 in q1.16
    localparam logic [THR_W-1:0] ONE_Q16 = 17'h10000;

    // item kinds
    localparam logic KIND_OBSERVE = 1'b0;
    localparam logic KIND_CLEAR   = 1'b1;

    // result field widths and stream data widths
    localparam int TOTAL_W  = 32;
    localparam int LEVEL_W  = 4;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 112;

    typedef struct packed {
        logic                      kind;
        logic signed [SCORE_W-1:0] taint_level;
        logic signed [SCORE_W-1:0] wave_level;
    } in_item_t;

    typedef struct packed {
        logic               over_limit;
        logic [TOTAL_W-1:0] lower_total;
        logic [TOTAL_W-1:0] raise_total;
        logic [LEVEL_W-1:0] level_peak;
        logic [LEVEL_W-1:0] level_now;
        logic [TOTAL_W-1:0] observe_total;
    } out_item_t;

endpackage

`default_nettype wire

[hdl/hysteresis_escalation_level_tracker.sv]
// ----------------------------------------------------------------------------
// hysteresis_escalation_level_tracker
// Tracks an escalation level with hysteresis from two clamped scores.
//
// Input stream s_*: one item is either an observation of two signed q2.16
// scores or a clear (s_tuser high). Output stream m_*: exactly one result
// item per input item, in order, carrying counters, current and peak level
// and the over-limit flag.
// Path: an accepted item is held in the input register, evaluated against
// the tracker state, and its result is registered in the result register
// once that register is free; m_tvalid is the result register's valid flag.
// Throughput: one item per cycle while results are taken; the level, hold
// and counter update is a single pass of compares and increments between
// the input register and the result register.
// Stall: when m_tready is low the result register holds, the input register
// fills, and s_tready drops until the result is taken.
// Reset: asynchronous, active low; clears all tracker state and both stages,
// and loads the configuration registers with their default values.
// Configuration writes are taken at any cycle and must only be issued while
// no items are in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module hysteresis_escalation_level_tracker
    import helt_pkg::*;
#(
    parameter int COUNT_BITS = 32,
    parameter int LEVEL_BITS = 4
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // wave_level[17:0], taint_level[35:18], zero fill
    input  wire logic [IN_DATA_W-1:0]   s_tdata,
    // kind
    input  wire logic                   s_tuser,
    input  wire logic                   s_tvalid,
    output      logic                   s_tready,
    // observe_total[31:0], level_now[35:32], level_peak[39:36],
    // raise_total[71:40], lower_total[103:72], over_limit[104], zero fill
    output      logic [OUT_DATA_W-1:0]  m_tdata,
    output      logic                   m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wr_data
);

    localparam int CW = (COUNT_BITS > TOTAL_W) ? COUNT_BITS : TOTAL_W;
    localparam int LW = (LEVEL_BITS > LEVEL_W) ? LEVEL_BITS : LEVEL_W;
    localparam logic [LW-1:0] LEVEL_MAX = LW'((1 << LEVEL_BITS) - 1);

    // configuration
    logic [LIMIT_W-1:0] limit_reg;
    logic [THR_W-1:0]   wave_up_reg;
    logic [THR_W-1:0]   wave_down_reg;
    logic [THR_W-1:0]   taint_up_reg;
    logic [THR_W-1:0]   taint_down_reg;
    logic [HOLD_W-1:0]  hold_reload_reg;

    // pipeline
    logic     in_valid_reg;
    in_item_t in_item_reg;
    logic     out_valid_reg;
    out_item_t out_item_reg;
    out_item_t out_item_next;

    // tracker state
    logic [COUNT_BITS-1:0] observe_reg, observe_next;
    logic [COUNT_BITS-1:0] raise_reg, raise_next;
    logic [COUNT_BITS-1:0] lower_reg, lower_next;
    logic [LEVEL_BITS-1:0] level_reg, level_next;
    logic [LEVEL_BITS-1:0] peak_reg, peak_next;
    logic [HOLD_W-1:0]     hold_reg, hold_next;
    logic                  over_next;

    logic advance;
    logic step;

    logic [THR_W-1:0]      wave_q, taint_q;
    logic [THR_W-1:0]      wu, wd, tu, td;
    logic [LW-1:0]         lim_wide;
    logic [LEVEL_BITS-1:0] lim;
    logic                  up, down;

    logic [CW-1:0] observe_w, raise_w, lower_w;
    logic [LW-1:0] level_w, peak_w;

    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'(out_item_reg);

    function automatic logic [THR_W-1:0] score_clamp(input logic [SCORE_W-1:0] raw);
        logic [THR_W-1:0] v;
        v = raw[THR_W-1:0];
        if (raw[SCORE_W-1])
            return '0;
        else if (v > ONE_Q16)
            return ONE_Q16;
        else
            return v;
    endfunction

    function automatic logic [THR_W-1:0] thr_clamp(input logic [THR_W-1:0] t);
        return (t > ONE_Q16) ? ONE_Q16 : t;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg       <= LIMIT_RST;
            wave_up_reg     <= WAVE_UP_RST;
            wave_down_reg   <= WAVE_DOWN_RST;
            taint_up_reg    <= TAINT_UP_RST;
            taint_down_reg  <= TAINT_DOWN_RST;
            hold_reload_reg <= HOLD_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_LEVEL_LIMIT: limit_reg       <= cfg_wr_data[LIMIT_W-1:0];
                REG_WAVE_UP:     wave_up_reg     <= cfg_wr_data[THR_W-1:0];
                REG_WAVE_DOWN:   wave_down_reg   <= cfg_wr_data[THR_W-1:0];
                REG_TAINT_UP:    taint_up_reg    <= cfg_wr_data[THR_W-1:0];
                REG_TAINT_DOWN:  taint_down_reg  <= cfg_wr_data[THR_W-1:0];
                REG_HOLD_RELOAD: hold_reload_reg <= cfg_wr_data[HOLD_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        wave_q = score_clamp(in_item_reg.wave_level);
        taint_q = score_clamp(in_item_reg.taint_level);
        wu = thr_clamp(wave_up_reg);
        tu = thr_clamp(taint_up_reg);
        wd = thr_clamp(wave_down_reg);
        td = thr_clamp(taint_down_reg);
        if (wd > wu)
            wd = wu;
        if (td > tu)
            td = tu;

        // limit saturates at the widest level
        lim_wide = (LW'(limit_reg) > LEVEL_MAX) ? LEVEL_MAX : LW'(limit_reg);
        lim      = lim_wide[LEVEL_BITS-1:0];

        up   = (wave_q >= wu) || (taint_q >= tu);
        down = (wave_q <= wd) && (taint_q <= td);

        observe_next = observe_reg;
        raise_next   = raise_reg;
        lower_next   = lower_reg;
        level_next   = level_reg;
        peak_next    = peak_reg;
        hold_next    = hold_reg;
        over_next    = 1'b0;

        if (in_item_reg.kind == KIND_CLEAR)
        begin
            observe_next = '0;
            raise_next   = '0;
            lower_next   = '0;
            level_next   = '0;
            peak_next    = '0;
            hold_next    = '0;
        end
        else
        begin
            observe_next = observe_reg + COUNT_BITS'(1);
            if (lim == '0)
            begin
                level_next = '0;
                hold_next  = '0;
            end
            else
            begin
                // a running hold blocks de-escalation
                if (hold_reg != '0)
                begin
                    hold_next = hold_reg - HOLD_W'(1);
                    down      = 1'b0;
                end
                if (up)
                begin
                    if (level_reg < lim)
                    begin
                        level_next = level_reg + LEVEL_BITS'(1);
                        raise_next = raise_reg + COUNT_BITS'(1);
                        hold_next  = hold_reload_reg;
                        if (level_next > peak_reg)
                            peak_next = level_next;
                    end
                    else
                    begin
                        over_next = 1'b1;
                    end
                end
                else if (down && level_reg != '0)
                begin
                    level_next = level_reg - LEVEL_BITS'(1);
                    lower_next = lower_reg + COUNT_BITS'(1);
                end
            end
        end

        observe_w = CW'(observe_next);
        raise_w   = CW'(raise_next);
        lower_w   = CW'(lower_next);
        level_w   = LW'(level_next);
        peak_w    = LW'(peak_next);

        out_item_next.observe_total = observe_w[TOTAL_W-1:0];
        out_item_next.level_now     = level_w[LEVEL_W-1:0];
        out_item_next.level_peak    = peak_w[LEVEL_W-1:0];
        out_item_next.raise_total   = raise_w[TOTAL_W-1:0];
        out_item_next.lower_total   = lower_w[TOTAL_W-1:0];
        out_item_next.over_limit    = over_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            observe_reg   <= '0;
            raise_reg     <= '0;
            lower_reg     <= '0;
            level_reg     <= '0;
            peak_reg      <= '0;
            hold_reg      <= '0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= in_valid_reg;
            if (step)
            begin
                observe_reg <= observe_next;
                raise_reg   <= raise_next;
                lower_reg   <= lower_next;
                level_reg   <= level_next;
                peak_reg    <= peak_next;
                hold_reg    <= hold_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg.wave_level  <= s_tdata[SCORE_W-1:0];
            in_item_reg.taint_level <= s_tdata[2*SCORE_W-1:SCORE_W];
            in_item_reg.kind        <= s_tuser;
        end
        if (step)
            out_item_reg <= out_item_next;
    end

    // the peak never falls below the current level
    assert property (@(posedge clk) disable iff (!rst_n) peak_reg >= level_reg)
        else $error("peak below current level");

    // an over-limit result always reports a non-zero level
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_item_reg.over_limit) |-> (out_item_reg.level_now != '0 ||
            LEVEL_BITS > LEVEL_W))
        else $error("over limit with level zero");

    // a clear item empties the tracker state
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && in_item_reg.kind == KIND_CLEAR) |=>
            (level_reg == '0 && peak_reg == '0 && observe_reg == '0 && hold_reg == '0))
        else $error("state not cleared");

    // state only moves when an item is evaluated
    assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> ($stable(observe_reg) && $stable(level_reg) && $stable(raise_reg)))
        else $error("state changed without an item");

    // a result is produced only from a held input item
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !in_valid_reg) |=> !m_tvalid)
        else $error("result without an item");

endmodule

`default_nettype wire

[tb/sv/level_tracker_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// level_tracker_checker
// Watches the register port and both streams of the escalation level tracker.
// Keeps its own copy of the registers and of the tracker state, works out
// the status item that each accepted input item should give, and compares
// every result field by field with the oldest status still awaited.
// ----------------------------------------------------------------------------

module level_tracker_checker
    import helt_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [IN_DATA_W-1:0]   s_tdata,
    input  wire logic                   s_tuser,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    input  wire logic [OUT_DATA_W-1:0]  m_tdata,
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wr_data,
    input  wire logic                   drain_done,
    output int                          fault_count,
    output int                          status_backlog
);

    localparam int STATUS_W = $bits(out_item_t);

    // register copy
    logic [LIMIT_W-1:0] limit_reg;
    logic [THR_W-1:0]   wave_up;
    logic [THR_W-1:0]   wave_down;
    logic [THR_W-1:0]   taint_up;
    logic [THR_W-1:0]   taint_down;
    logic [HOLD_W-1:0]  hold_reload;

    // tracker state copy
    logic [TOTAL_W-1:0] observes;
    logic [TOTAL_W-1:0] raises;
    logic [TOTAL_W-1:0] lowers;
    logic [LEVEL_W-1:0] level;
    logic [LEVEL_W-1:0] peak;
    logic [HOLD_W-1:0]  hold_left;

    out_item_t awaited_status[$];
    logic      leftover_checked;

    function automatic logic [THR_W-1:0] clamp_score(input logic signed [SCORE_W-1:0] raw);
        if (raw < 0)
            return '0;
        if (raw > $signed({1'b0, ONE_Q16}))
            return ONE_Q16;
        return raw[THR_W-1:0];
    endfunction

    function automatic logic [THR_W-1:0] cap_one(input logic [THR_W-1:0] thr);
        return (thr > ONE_Q16) ? ONE_Q16 : thr;
    endfunction

    task automatic log_fault(input string what);
        $display("mismatch at %0t: %s", $time, what);
        fault_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            log_fault($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task automatic track_item(input logic kind, input logic [SCORE_W-1:0] wave_raw,
                              input logic [SCORE_W-1:0] taint_raw, output out_item_t status);
        logic [THR_W-1:0] wave;
        logic [THR_W-1:0] taint;
        logic [THR_W-1:0] w_up;
        logic [THR_W-1:0] w_down;
        logic [THR_W-1:0] t_up;
        logic [THR_W-1:0] t_down;
        logic             rise;
        logic             fall;
        logic             over;
        over = 1'b0;
        if (kind == KIND_CLEAR)
        begin
            observes  = '0;
            raises    = '0;
            lowers    = '0;
            level     = '0;
            peak      = '0;
            hold_left = '0;
        end
        else
        begin
            wave   = clamp_score(wave_raw);
            taint  = clamp_score(taint_raw);
            w_up   = cap_one(wave_up);
            t_up   = cap_one(taint_up);
            w_down = cap_one(wave_down);
            t_down = cap_one(taint_down);
            if (w_down > w_up)
                w_down = w_up;
            if (t_down > t_up)
                t_down = t_up;
            observes = observes + TOTAL_W'(1);
            if (limit_reg == '0)
            begin
                level     = '0;
                hold_left = '0;
            end
            else
            begin
                rise = (wave >= w_up) || (taint >= t_up);
                fall = (wave <= w_down) && (taint <= t_down);
                // a running hold blocks the way down
                if (hold_left != '0)
                begin
                    hold_left = hold_left - HOLD_W'(1);
                    fall      = 1'b0;
                end
                if (rise)
                begin
                    if (level < limit_reg)
                    begin
                        level     = level + LEVEL_W'(1);
                        raises    = raises + TOTAL_W'(1);
                        hold_left = hold_reload;
                        if (level > peak)
                            peak = level;
                    end
                    else
                        over = 1'b1;
                end
                else if (fall && level != '0)
                begin
                    level  = level - LEVEL_W'(1);
                    lowers = lowers + TOTAL_W'(1);
                end
            end
        end
        status.observe_total = observes;
        status.level_now     = level;
        status.level_peak    = peak;
        status.raise_total   = raises;
        status.lower_total   = lowers;
        status.over_limit    = over;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        out_item_t seen;
        if (!rst_n)
        begin
            limit_reg        = LIMIT_RST;
            wave_up          = WAVE_UP_RST;
            wave_down        = WAVE_DOWN_RST;
            taint_up         = TAINT_UP_RST;
            taint_down       = TAINT_DOWN_RST;
            hold_reload      = HOLD_RST;
            observes         = '0;
            raises           = '0;
            lowers           = '0;
            level            = '0;
            peak             = '0;
            hold_left        = '0;
            leftover_checked = 1'b0;
            fault_count      = 0;
            awaited_status.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (awaited_status.size() == 0)
                    log_fault("result item with no status awaited");
                else
                begin
                    want = awaited_status.pop_front();
                    seen = out_item_t'(m_tdata[STATUS_W-1:0]);
                    check_field("observe_total", seen.observe_total, want.observe_total);
                    check_field("level_now", 32'(seen.level_now), 32'(want.level_now));
                    check_field("level_peak", 32'(seen.level_peak), 32'(want.level_peak));
                    check_field("raise_total", seen.raise_total, want.raise_total);
                    check_field("lower_total", seen.lower_total, want.lower_total);
                    check_field("over_limit", 32'(seen.over_limit), 32'(want.over_limit));
                    check_field("zero fill", 32'(m_tdata[OUT_DATA_W-1:STATUS_W]), 32'd0);
                end
            end
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_LEVEL_LIMIT: limit_reg   = cfg_wr_data[LIMIT_W-1:0];
                    REG_WAVE_UP:     wave_up     = cfg_wr_data[THR_W-1:0];
                    REG_WAVE_DOWN:   wave_down   = cfg_wr_data[THR_W-1:0];
                    REG_TAINT_UP:    taint_up    = cfg_wr_data[THR_W-1:0];
                    REG_TAINT_DOWN:  taint_down  = cfg_wr_data[THR_W-1:0];
                    REG_HOLD_RELOAD: hold_reload = cfg_wr_data[HOLD_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                track_item(s_tuser, s_tdata[SCORE_W-1:0], s_tdata[2*SCORE_W-1:SCORE_W], want);
                awaited_status.push_back(want);
            end
            if (drain_done && !leftover_checked)
            begin
                leftover_checked = 1'b1;
                if (awaited_status.size() != 0)
                    log_fault($sformatf("%0d status items never arrived",
                                        awaited_status.size()));
            end
        end
        status_backlog = awaited_status.size();
    end

endmodule

[tb/sv/tb_hysteresis_escalation_level_tracker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hysteresis_escalation_level_tracker
// Drives the escalation level tracker through a series of register settings,
// from the defaults to the extremes, with directed score pairs and clears
// followed by random rising, calming and noisy runs under random gaps and
// back pressure; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------

module tb_hysteresis_escalation_level_tracker;
    import helt_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = REG_HOLD_RELOAD + 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = REG_HOLD_RELOAD + 3'd2;
    localparam int PHASE_ITEMS = 216;

    typedef enum int {MOOD_RISING, MOOD_CALMING, MOOD_NOISE} mood_t;

    logic                   clk;
    logic                   rst_n;
    logic [IN_DATA_W-1:0]   s_tdata;
    logic                   s_tuser;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wr_data;
    logic                   drain_done;
    int                     fault_count;
    int                     status_backlog;

    // effective thresholds of the current setting, used to aim the scores
    logic [THR_W-1:0] aim_wave_up;
    logic [THR_W-1:0] aim_wave_down;
    logic [THR_W-1:0] aim_taint_up;
    logic [THR_W-1:0] aim_taint_down;
    int               quiet_left;

    int corner_scores[7] = '{-131072, -1, 0, 65535, 65536, 65537, 131071};

    hysteresis_escalation_level_tracker u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .m_tdata     (m_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    level_tracker_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .m_tdata        (m_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .drain_done     (drain_done),
        .fault_count    (fault_count),
        .status_backlog (status_backlog)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic logic [THR_W-1:0] cap_one(input logic [THR_W-1:0] thr);
        return (thr > ONE_Q16) ? ONE_Q16 : thr;
    endfunction

    function automatic logic [SCORE_W-1:0] any_score();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return SCORE_W'(corner_scores[$urandom_range(0, 6)]);
        if (r < 30)
            return SCORE_W'($urandom);
        return SCORE_W'($urandom_range(0, 65536));
    endfunction

    function automatic logic [SCORE_W-1:0] near_score(input logic [THR_W-1:0] thr);
        int v;
        v = int'(thr) + int'($urandom_range(0, 6)) - 3;
        return SCORE_W'(v);
    endfunction

    function automatic logic [SCORE_W-1:0] above_score(input logic [THR_W-1:0] thr);
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return near_score(thr);
        if (r < 35)
            return SCORE_W'($urandom_range(65536, 131071));
        return SCORE_W'($urandom_range(thr, 65536));
    endfunction

    function automatic logic [SCORE_W-1:0] calm_score(input logic [THR_W-1:0] thr);
        if ($urandom_range(0, 3) == 0)
            return near_score(thr);
        return SCORE_W'($urandom_range(0, thr));
    endfunction

    task automatic send_item(input logic kind, input logic [SCORE_W-1:0] wave,
                             input logic [SCORE_W-1:0] taint);
        int gap;
        int r;
        if (quiet_left > 0)
        begin
            quiet_left--;
            gap = 0;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
            begin
                quiet_left = $urandom_range(20, 60);
                gap = 0;
            end
            else if (r < 55)
                gap = 0;
            else if (r < 90)
                gap = $urandom_range(1, 3);
            else
                gap = $urandom_range(5, 30);
        end
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(IN_DATA_W - 2*SCORE_W){1'b0}}, taint, wave};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic observe(input int wave, input int taint);
        send_item(KIND_OBSERVE, wave[SCORE_W-1:0], taint[SCORE_W-1:0]);
    endtask

    // hold the sender until every status item is back
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (status_backlog != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
    endtask

    task automatic program_regs(input logic [LIMIT_W-1:0] limit,
                                input logic [THR_W-1:0] wu, input logic [THR_W-1:0] wd,
                                input logic [THR_W-1:0] tu, input logic [THR_W-1:0] td,
                                input logic [HOLD_W-1:0] hold);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        write_reg(REG_SPARE_LO, junk);
        junk = CFG_DATA_W'($urandom);
        junk[LIMIT_W-1:0] = limit;
        write_reg(REG_LEVEL_LIMIT, junk);
        write_reg(REG_WAVE_UP, wu);
        write_reg(REG_WAVE_DOWN, wd);
        write_reg(REG_TAINT_UP, tu);
        write_reg(REG_TAINT_DOWN, td);
        junk = CFG_DATA_W'($urandom);
        junk[HOLD_W-1:0] = hold;
        write_reg(REG_HOLD_RELOAD, junk);
        junk = CFG_DATA_W'($urandom);
        write_reg(REG_SPARE_HI, junk);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        aim_wave_up    = cap_one(wu);
        aim_taint_up   = cap_one(tu);
        aim_wave_down  = (cap_one(wd) > aim_wave_up) ? aim_wave_up : cap_one(wd);
        aim_taint_down = (cap_one(td) > aim_taint_up) ? aim_taint_up : cap_one(td);
    endtask

    task automatic random_run(input int count);
        mood_t            mood;
        int               mood_left;
        int               pause_at;
        int               r;
        logic [SCORE_W-1:0] wave;
        logic [SCORE_W-1:0] taint;
        mood      = MOOD_NOISE;
        mood_left = 0;
        pause_at  = $urandom_range(count / 4, 3 * count / 4);
        for (int i = 0; i < count; i++)
        begin
            if (mood_left == 0)
            begin
                r = $urandom_range(0, 9);
                mood = (r < 4) ? MOOD_RISING : (r < 8) ? MOOD_CALMING : MOOD_NOISE;
                mood_left = $urandom_range(2, 12);
            end
            mood_left--;
            if (i == pause_at)
                settle();
            if ($urandom_range(0, 59) == 0)
                send_item(KIND_CLEAR, SCORE_W'($urandom), SCORE_W'($urandom));
            else
            begin
                case (mood)
                    MOOD_RISING:
                    begin
                        if ($urandom_range(0, 1) == 0)
                        begin
                            wave  = above_score(aim_wave_up);
                            taint = any_score();
                        end
                        else
                        begin
                            wave  = any_score();
                            taint = above_score(aim_taint_up);
                        end
                    end
                    MOOD_CALMING:
                    begin
                        wave  = calm_score(aim_wave_down);
                        taint = calm_score(aim_taint_down);
                    end
                    default:
                    begin
                        wave  = any_score();
                        taint = any_score();
                    end
                endcase
                send_item(KIND_OBSERVE, wave, taint);
            end
        end
    endtask

    initial
    begin
        int r;
        int len;
        logic lvl;
        m_tready = 1'b0;
        forever
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
            begin
                lvl = 1'b1;
                len = $urandom_range(30, 100);
            end
            else if (r < 60)
            begin
                lvl = 1'b1;
                len = $urandom_range(1, 8);
            end
            else if (r < 92)
            begin
                lvl = 1'b0;
                len = $urandom_range(1, 3);
            end
            else
            begin
                lvl = 1'b0;
                len = $urandom_range(10, 40);
            end
            @(negedge clk);
            m_tready <= lvl;
            repeat (len - 1) @(negedge clk);
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tuser        = KIND_OBSERVE;
        s_tdata        = '0;
        cfg_wr_en      = 1'b0;
        cfg_index      = REG_LEVEL_LIMIT;
        cfg_wr_data    = '0;
        drain_done     = 1'b0;
        quiet_left     = 0;
        aim_wave_up    = WAVE_UP_RST;
        aim_wave_down  = WAVE_DOWN_RST;
        aim_taint_up   = TAINT_UP_RST;
        aim_taint_down = TAINT_DOWN_RST;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // default registers: climb to the limit, hold, then step down
        observe(0, 0);
        observe(-131072, 131071);
        observe(40632, 0);
        observe(40631, 38012);
        observe(65536, 65537);
        observe(-1, -1);
        observe(18350, 15729);
        observe(18351, 0);
        observe(0, 15730);
        observe(40631, 38011);
        send_item(KIND_CLEAR, SCORE_W'($urandom), SCORE_W'($urandom));
        observe(131071, -131072);
        observe(65535, 0);
        send_item(KIND_CLEAR, '0, '0);
        random_run(PHASE_ITEMS);

        settle();
        program_regs(4'd15, 17'd30000, 17'd20000, 17'd30000, 17'd20000, 8'd0);
        random_run(PHASE_ITEMS);
        repeat (16) observe(65536, -131072);

        // limit lowered below the level reached
        settle();
        program_regs(4'd2, 17'd30000, 17'd20000, 17'd30000, 17'd20000, 8'd1);
        observe(70000, 0);
        repeat (3) observe(0, 0);
        observe(0, 65536);
        random_run(PHASE_ITEMS);

        // tracking off
        settle();
        program_regs(4'd0, 17'd40000, 17'd10000, 17'd40000, 17'd10000, 8'd3);
        observe(65536, 65536);
        observe(0, 0);
        random_run(PHASE_ITEMS);

        settle();
        program_regs(4'd1, 17'd0, 17'd0, 17'd0, 17'd0, 8'd255);
        random_run(PHASE_ITEMS);

        // thresholds above one, down at or above up
        settle();
        program_regs(4'd7, 17'h1FFFF, 17'h1FFFF, 17'd65537, 17'h1FFFF, 8'd0);
        random_run(PHASE_ITEMS);

        settle();
        program_regs(4'd15, ONE_Q16, 17'd0, 17'd1, 17'd0, 8'd5);
        random_run(PHASE_ITEMS);

        settle();
        program_regs(LIMIT_W'($urandom_range(1, 15)), THR_W'($urandom_range(1000, 65536)),
                     THR_W'($urandom_range(0, 65536)), THR_W'($urandom_range(1000, 65536)),
                     THR_W'($urandom_range(0, 65536)), HOLD_W'($urandom_range(0, 6)));
        random_run(PHASE_ITEMS);

        @(negedge clk);
        s_tvalid <= 1'b0;
        for (int n = 0; n < 20000 && status_backlog != 0; n++)
            @(negedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
        drain_done = 1'b1;
        @(negedge clk);
        if (fault_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
